// ----- design/fbba_pkg.sv -----
// Shared constants, codes and beat types of the fixed block bitmap allocator.
package fbba_pkg;

	localparam int BLOCKS_PER_PAGE = 1024;
	localparam int BLOCK_BYTES     = 32;
	localparam int MAX_PAGES       = 8;

	// Bitmap RAM word: one bit per block, set means free.
	localparam int WORD_BITS      = 32;
	localparam int WORDS_PER_PAGE = BLOCKS_PER_PAGE / WORD_BITS;
	localparam int TOTAL_WORDS    = MAX_PAGES * WORDS_PER_PAGE;

	localparam int PAGE_W  = $clog2(MAX_PAGES);
	localparam int WSEL_W  = $clog2(WORDS_PER_PAGE);
	localparam int BIT_W   = $clog2(WORD_BITS);
	localparam int WADDR_W = PAGE_W + WSEL_W;
	localparam int BOFF_W  = $clog2(BLOCK_BYTES);
	localparam int FULL_W  = PAGE_W + WSEL_W + BIT_W + BOFF_W;

	localparam int ADDR_W   = 20;
	localparam int BADDR_W  = 18;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 4;

	localparam logic [ADDR_W:0] POOL_LIMIT =
		(ADDR_W + 1)'(MAX_PAGES * BLOCKS_PER_PAGE * BLOCK_BYTES);

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FREED     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OOM       = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 2'd3;

	typedef struct packed {
		logic              action;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BADDR_W-1:0]  block_address;
		logic [COUNT_W-1:0]  pages_active;
	} rsp_t;

endpackage

// ----- design/fbba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fbba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/fixed_block_bitmap_allocator.sv -----
// Steps from request beat to response beat: accept, page pick, word pick and RAM read, then
// bit update and write-back; a bad address or out of memory answers from the page pick.
// A new request is taken only in the idle state, after the last one is answered; a rejected
// request skips the RAM. A response waiting downstream stalls the final step only.
// Reset: async, active low. The per-word all-free flags cover the bitmap RAM, so no
// clearing pass runs; only page 0 is active and the block is ready right after reset.
module fixed_block_bitmap_allocator
	import fbba_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PAGE = 2'd1;
	localparam logic [1:0] S_WORD = 2'd2;
	localparam logic [1:0] S_BIT  = 2'd3;

	logic [1:0]             state_q;
	req_t                   req_q;
	logic [PAGE_W-1:0]      page_q;
	logic [WSEL_W-1:0]      word_q;
	logic                   word_all_q;
	logic [TOTAL_WORDS-1:0] any_q;   // word still has a free block
	logic [TOTAL_WORDS-1:0] all_q;   // word is entirely free; RAM content then ignored
	logic [MAX_PAGES-1:0]   active_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	logic                      out_free;
	logic [MAX_PAGES-1:0]      page_free;
	logic                      act_hit, ina_hit;
	logic [PAGE_W-1:0]         act_sel, ina_sel;
	logic                      in_pool;
	logic [PAGE_W-1:0]         addr_page;
	logic [WSEL_W-1:0]         addr_word;
	logic [BIT_W-1:0]          addr_bit;
	logic [WORDS_PER_PAGE-1:0] page_any;
	logic [WSEL_W-1:0]         first_word;
	logic [WSEL_W-1:0]         word_sel;
	logic                      ram_re;
	logic [WADDR_W-1:0]        ram_raddr;
	logic [WORD_BITS-1:0]      ram_rdata;
	logic                      ram_we;
	logic [WADDR_W-1:0]        ram_waddr;
	logic [WORD_BITS-1:0]      cur_word;
	logic [BIT_W-1:0]          first_bit;
	logic [BIT_W-1:0]          bit_sel;
	logic [WORD_BITS-1:0]      new_word;
	logic                      new_any, new_all;
	logic [WORDS_PER_PAGE-1:0] page_all;
	logic                      page_empty;
	logic [MAX_PAGES-1:0]      active_next;
	logic [FULL_W-1:0]         full_addr;

	function automatic logic [COUNT_W-1:0] count_pages(input logic [MAX_PAGES-1:0] v);
		logic [COUNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < MAX_PAGES; i++) begin
			n = n + COUNT_W'(v[i]);
		end
		return n;
	endfunction

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Address split for a free request.
	assign in_pool   = ({1'b0, req_q.address} < POOL_LIMIT);
	assign addr_page = req_q.address[BOFF_W + BIT_W + WSEL_W +: PAGE_W];
	assign addr_word = req_q.address[BOFF_W + BIT_W +: WSEL_W];
	assign addr_bit  = req_q.address[BOFF_W +: BIT_W];

	// Page pick: lowest active page with a free block, else lowest inactive page.
	always_comb begin
		act_hit = 1'b0;
		ina_hit = 1'b0;
		act_sel = '0;
		ina_sel = '0;
		for (int p = 0; p < MAX_PAGES; p++) begin
			page_free[p] = |any_q[p * WORDS_PER_PAGE +: WORDS_PER_PAGE];
		end
		for (int p = MAX_PAGES - 1; p >= 0; p--) begin
			if (active_q[p] && page_free[p]) begin
				act_hit = 1'b1;
				act_sel = PAGE_W'(p);
			end
			if (!active_q[p]) begin
				ina_hit = 1'b1;
				ina_sel = PAGE_W'(p);
			end
		end
	end

	// Word pick within the chosen page.
	always_comb begin
		page_any   = any_q[{page_q, {WSEL_W{1'b0}}} +: WORDS_PER_PAGE];
		first_word = '0;
		for (int w = WORDS_PER_PAGE - 1; w >= 0; w--) begin
			if (page_any[w]) begin
				first_word = WSEL_W'(w);
			end
		end
		word_sel = (req_q.action == ACT_ALLOC) ? first_word : addr_word;
	end

	assign ram_re    = (state_q == S_WORD);
	assign ram_raddr = {page_q, word_sel};

	// Bit update on the word read back.
	always_comb begin
		cur_word  = word_all_q ? '1 : ram_rdata;
		first_bit = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (cur_word[b]) begin
				first_bit = BIT_W'(b);
			end
		end
		bit_sel  = (req_q.action == ACT_ALLOC) ? first_bit : addr_bit;
		new_word = cur_word;
		new_word[bit_sel] = (req_q.action == ACT_FREE);
		new_any  = |new_word;
		new_all  = &new_word;
		page_all = all_q[{page_q, {WSEL_W{1'b0}}} +: WORDS_PER_PAGE];
		page_all[word_q] = new_all;
		page_empty  = &page_all;
		active_next = active_q;
		if (req_q.action == ACT_ALLOC) begin
			active_next[page_q] = 1'b1;
		end else if (page_q != '0 && page_empty) begin
			active_next[page_q] = 1'b0;
		end
		full_addr = {page_q, word_q, first_bit, {BOFF_W{1'b0}}};
	end

	assign ram_we    = (state_q == S_BIT) && out_free;
	assign ram_waddr = {page_q, word_q};

	fbba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(TOTAL_WORDS)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(new_word),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			any_q       <= '1;
			all_q       <= '1;
			active_q    <= MAX_PAGES'(1);
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_PAGE;
					end
				end
				S_PAGE: begin
					if (req_q.action == ACT_ALLOC) begin
						if (act_hit || ina_hit) begin
							state_q <= S_WORD;
						end else if (out_free) begin
							rsp_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end
					end else begin
						if (in_pool && active_q[addr_page]) begin
							state_q <= S_WORD;
						end else if (out_free) begin
							rsp_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end
					end
				end
				S_WORD: begin
					state_q <= S_BIT;
				end
				S_BIT: begin
					if (out_free) begin
						any_q[ram_waddr] <= new_any;
						all_q[ram_waddr] <= new_all;
						active_q         <= active_next;
						rsp_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers, no reset.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (state_q == S_PAGE) begin
			if (req_q.action == ACT_ALLOC) begin
				page_q <= act_hit ? act_sel : ina_sel;
				if (!act_hit && !ina_hit && out_free) begin
					rsp_q.status        <= ST_OOM;
					rsp_q.block_address <= '0;
					rsp_q.pages_active  <= count_pages(active_q);
				end
			end else begin
				page_q <= addr_page;
				if (!(in_pool && active_q[addr_page]) && out_free) begin
					rsp_q.status        <= ST_BAD_ADDR;
					rsp_q.block_address <= '0;
					rsp_q.pages_active  <= count_pages(active_q);
				end
			end
		end
		if (state_q == S_WORD) begin
			word_q     <= word_sel;
			word_all_q <= all_q[ram_raddr];
		end
		if (state_q == S_BIT && out_free) begin
			rsp_q.pages_active <= count_pages(active_next);
			if (req_q.action == ACT_ALLOC) begin
				rsp_q.status        <= ST_ALLOCATED;
				rsp_q.block_address <= BADDR_W'(full_addr);
			end else begin
				rsp_q.status        <= ST_FREED;
				rsp_q.block_address <= '0;
			end
		end
	end

endmodule

// ----- design/fbba_checker.sv -----
// Port-level checks for the fixed block bitmap allocator, bound to the top level.
module fbba_checker
	import fbba_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// A request beat keeps the block busy for the next cycle.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready high right after a request beat");

	// Only an allocation carries a block address.
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_ALLOCATED |-> rsp.block_address == '0)
		else $error("nonzero block address on a non-allocate response");

	// Page 0 is always active and the count never exceeds the pool.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.pages_active != '0 &&
			rsp.pages_active <= COUNT_W'(MAX_PAGES))
		else $error("pages_active out of range");

	// Out of memory only when every page is active.
	a_oom_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_OOM |-> rsp.pages_active == COUNT_W'(MAX_PAGES))
		else $error("out of memory with an inactive page left");

	// A stalled response beat holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

endmodule

bind fixed_block_bitmap_allocator fbba_checker u_fbba_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
